@@ rtl/epce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package epce_pkg;

   // Default sizes for the top-level parameters.
   localparam int POOL_BYTES_DEFAULT = 512;
   localparam int MAX_CREDIT_DEFAULT = 4096;

   // Fixed sizes of the cipher stage.
   localparam int KEY_BYTES   = 32;
   localparam int BLOCK_BYTES = 64;
   localparam int DROUNDS     = 10;

   // Item opcodes.
   localparam logic [1:0] OP_MIX     = 2'd0;
   localparam logic [1:0] OP_EXTRACT = 2'd1;
   localparam logic [1:0] OP_DEBIT   = 2'd2;

   // ChaCha constant words ("expand 32-byte k").
   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   typedef enum logic [2:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_DIAG,
      CORE_UNDIAG,
      CORE_EMIT
   } core_state_type;

   // Request from the pool logic to the cipher core.
   typedef struct packed {
      logic       start;
      logic [6:0] len;
   } core_ctl_type;

   // Keystream bytes coming back from the cipher core.
   typedef struct packed {
      logic       byte_valid;
      logic       byte_last;
      logic [7:0] data;
   } core_sts_type;

   // Initial state word: constants, key words, then zero counter and nonce.
   function automatic logic [31:0] init_word(input logic [3:0] idx,
                                             input logic [255:0] key);
      logic [2:0]  kw;
      logic [31:0] w;
      kw = 3'(idx - 4'd4);
      case (idx)
         4'd0: w = SIGMA0;
         4'd1: w = SIGMA1;
         4'd2: w = SIGMA2;
         4'd3: w = SIGMA3;
         4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: w = key[32*kw +: 32];
         default: w = 32'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/epce_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module epce_core
   import epce_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [255:0] key,
   input  wire core_ctl_type ctl,
   output core_sts_type      sts
);

   core_state_type state_ff, state_in;

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] upd  [16];
   logic [1:0]  step_ff, step_in;
   logic [1:0]  qr_ff, qr_in;
   logic        half_ff, half_in;
   logic [3:0]  dround_ff, dround_in;
   logic [5:0]  k_ff, k_in;
   logic [6:0]  len_ff, len_in;

   logic [31:0] p, q, r, x, t, y;
   logic [31:0] sum;
   logic        last_byte;

   // Shared add, xor and rotate unit working on column zero.
   always_comb begin
      p = step_ff[0] ? w_ff[8]  : w_ff[0];
      q = step_ff[0] ? w_ff[12] : w_ff[4];
      r = step_ff[0] ? w_ff[4]  : w_ff[12];
      x = p + q;
      t = r ^ x;
      case (step_ff)
         2'd0:    y = {t[15:0], t[31:16]};
         2'd1:    y = {t[19:0], t[31:20]};
         2'd2:    y = {t[23:0], t[31:24]};
         default: y = {t[24:0], t[31:25]};
      endcase
   end

   // Feed-forward add for the word now at the head of the state.
   assign sum = w_ff[0] + init_word(k_ff[5:2], key);
   assign last_byte = ({1'b0, k_ff} == 7'(len_ff - 7'd1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CORE_IDLE: begin
            if (ctl.start) state_in = CORE_ROUND;
         end
         CORE_ROUND: begin
            if (step_ff == 2'd3 && qr_ff == 2'd3) begin
               state_in = half_ff ? CORE_UNDIAG : CORE_DIAG;
            end
         end
         CORE_DIAG: state_in = CORE_ROUND;
         CORE_UNDIAG: begin
            if (dround_ff == 4'(DROUNDS - 1)) state_in = CORE_EMIT;
            else state_in = CORE_ROUND;
         end
         CORE_EMIT: begin
            if (last_byte) state_in = CORE_IDLE;
         end
         default: state_in = CORE_IDLE;
      endcase
   end

   // Outputs toward the pool logic.
   always_comb begin
      sts.byte_valid = (state_ff == CORE_EMIT);
      sts.byte_last  = last_byte;
      case (k_ff[1:0])
         2'd0:    sts.data = sum[7:0];
         2'd1:    sts.data = sum[15:8];
         2'd2:    sts.data = sum[23:16];
         default: sts.data = sum[31:24];
      endcase
   end

   // Working state and counters.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         w_in[i] = w_ff[i];
         upd[i]  = w_ff[i];
      end
      step_in   = step_ff;
      qr_in     = qr_ff;
      half_in   = half_ff;
      dround_in = dround_ff;
      k_in      = k_ff;
      len_in    = len_ff;
      if (step_ff[0]) begin
         upd[8] = x;
         upd[4] = y;
      end else begin
         upd[0]  = x;
         upd[12] = y;
      end
      case (state_ff)
         CORE_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 16; i++) w_in[i] = init_word(4'(i), key);
               step_in   = 2'd0;
               qr_in     = 2'd0;
               half_in   = 1'b0;
               dround_in = 4'd0;
               len_in    = ctl.len;
            end
         end
         CORE_ROUND: begin
            // After the last step of a quarter round, the next column moves in.
            if (step_ff == 2'd3) begin
               for (int rr = 0; rr < 4; rr++) begin
                  for (int c = 0; c < 4; c++) begin
                     w_in[4*rr + c] = upd[4*rr + ((c + 1) % 4)];
                  end
               end
               qr_in = qr_ff + 2'd1;
               if (qr_ff == 2'd3) half_in = ~half_ff;
            end else begin
               for (int i = 0; i < 16; i++) w_in[i] = upd[i];
            end
            step_in = step_ff + 2'd1;
         end
         CORE_DIAG: begin
            // Line the diagonals up as columns.
            for (int rr = 0; rr < 4; rr++) begin
               for (int c = 0; c < 4; c++) begin
                  w_in[4*rr + c] = w_ff[4*rr + ((c + rr) % 4)];
               end
            end
         end
         CORE_UNDIAG: begin
            for (int rr = 0; rr < 4; rr++) begin
               for (int c = 0; c < 4; c++) begin
                  w_in[4*rr + c] = w_ff[4*rr + ((c - rr + 4) % 4)];
               end
            end
            dround_in = dround_ff + 4'd1;
            k_in      = 6'd0;
         end
         CORE_EMIT: begin
            // Shift one word forward after its fourth byte.
            if (k_ff[1:0] == 2'd3) begin
               for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            end
            k_in = k_ff + 6'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      for (int i = 0; i < 16; i++) w_ff[i] <= w_in[i];
      step_ff   <= step_in;
      qr_ff     <= qr_in;
      half_ff   <= half_in;
      dround_ff <= dround_in;
      k_ff      <= k_in;
      len_ff    <= len_in;
   end

endmodule

`default_nettype wire

@@ rtl/entropy_pool_chacha_extractor_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Handshake
// input     req_opcode .. req_out_len               start high while busy low
// result    rsp_out_byte .. rsp_entropy_count       rsp_valid, one cycle each
//
// Mix, debit and refused or empty extract items give one result in the next
// cycle and a new item can be taken every cycle. A granted extract runs the
// cipher core one add-xor-rotate step a cycle: 320 steps plus 20 row shuffles,
// then one result per requested byte, all with busy high. Reset clears
// the pool key bytes, write position and count at once. Results cannot stall.
module entropy_pool_chacha_extractor_top
   import epce_pkg::*;
#(
   parameter int POOL_BYTES = POOL_BYTES_DEFAULT,
   parameter int MAX_CREDIT = MAX_CREDIT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_last,
   input  wire logic [12:0] req_amount_bits,
   input  wire logic [6:0]  req_out_len,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_granted,
   output logic             rsp_end_of_run,
   output logic [12:0]      rsp_entropy_count
);

   localparam int IW  = $clog2(POOL_BYTES);
   localparam int CL  = $clog2(MAX_CREDIT + 1);
   localparam int CW  = (CL > 13) ? CL : 13;

   // Only the first key-sized part of the pool ever feeds the cipher.
   logic [7:0]    key_ff [KEY_BYTES];
   logic [7:0]    key_in [KEY_BYTES];
   logic [255:0]  key_vec;
   logic [IW-1:0] widx_ff, widx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_granted_ff, rsp_granted_in;
   logic          rsp_end_ff, rsp_end_in;
   logic [12:0]   rsp_count_ff, rsp_count_in;

   logic          accept;
   logic [CW-1:0] amount;
   logic [CW:0]   credit_sum;
   logic [CW-1:0] need;
   logic          key_hit;
   core_ctl_type  ctl;
   core_sts_type  sts;

   assign accept = start && !busy_ff;
   assign amount = CW'(req_amount_bits);
   assign need   = CW'({req_out_len, 3'b000});
   assign credit_sum = {1'b0, count_ff} + {1'b0, amount};
   assign key_hit = ({1'b0, widx_ff} < (IW + 1)'(KEY_BYTES));

   always_comb begin
      for (int n = 0; n < KEY_BYTES; n++) key_vec[8*n +: 8] = key_ff[n];
   end

   // Item decode, pool and credit updates.
   always_comb begin
      for (int n = 0; n < KEY_BYTES; n++) key_in[n] = key_ff[n];
      widx_in        = widx_ff;
      count_in       = count_ff;
      busy_in        = busy_ff;
      ctl.start      = 1'b0;
      ctl.len        = req_out_len;
      rsp_valid_in   = 1'b0;
      rsp_byte_in    = 8'd0;
      rsp_granted_in = 1'b1;
      rsp_end_in     = 1'b1;
      rsp_count_in   = count_ff[12:0];
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_opcode)
            OP_MIX: begin
               if (req_byte_present) begin
                  if (key_hit) begin
                     key_in[widx_ff[4:0]] = key_ff[widx_ff[4:0]] ^ req_data_byte;
                  end
                  if (widx_ff == IW'(POOL_BYTES - 1)) widx_in = '0;
                  else widx_in = widx_ff + IW'(1);
               end
               if (req_last) begin
                  if (credit_sum > (CW + 1)'(MAX_CREDIT)) count_in = CW'(MAX_CREDIT);
                  else count_in = credit_sum[CW-1:0];
               end
            end
            OP_DEBIT: begin
               count_in = (count_ff > amount) ? count_ff - amount : '0;
            end
            OP_EXTRACT: begin
               if (req_out_len == 7'd0) begin
                  rsp_granted_in = 1'b1;
               end else if (req_out_len > 7'(BLOCK_BYTES) || count_ff < need) begin
                  rsp_granted_in = 1'b0;
               end else begin
                  // Granted: the results come from the cipher core later.
                  count_in     = count_ff - need;
                  busy_in      = 1'b1;
                  ctl.start    = 1'b1;
                  rsp_valid_in = 1'b0;
               end
            end
            default: rsp_granted_in = 1'b0;
         endcase
         rsp_count_in = count_in[12:0];
      end else if (sts.byte_valid) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = sts.data;
         rsp_end_in   = sts.byte_last;
         if (sts.byte_last) busy_in = 1'b0;
      end
   end

   epce_core u_core (
      .clock (clock),
      .reset (reset),
      .key   (key_vec),
      .ctl   (ctl),
      .sts   (sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < KEY_BYTES; n++) key_ff[n] <= 8'd0;
         widx_ff      <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int n = 0; n < KEY_BYTES; n++) key_ff[n] <= key_in[n];
         widx_ff      <= widx_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff    <= rsp_byte_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_end_ff     <= rsp_end_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_end_of_run    = rsp_end_ff;
   assign rsp_entropy_count = rsp_count_ff;

endmodule

`default_nettype wire

@@ bench/tb_entropy_pool_chacha_extractor_top.sv @@
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the pool, the write position and the credit
// count, and turns every accepted item into the results the block should emit.
class pool_scoreboard;
   typedef struct {
      logic [7:0]  out_byte;
      logic        granted;
      logic        end_of_run;
      logic [12:0] entropy_count;
   } result_type;

   logic [7:0]  pool[512];
   int          wr_pos;
   int          credit;
   logic [31:0] wk[16];
   result_type  pending[$];
   int          errors;
   int          n_results;
   int          n_grants;
   int          n_refusals;

   function new();
      foreach (pool[i]) pool[i] = 8'd0;
      wr_pos = 0;
      credit = 0;
      errors = 0;
      n_results = 0;
      n_grants = 0;
      n_refusals = 0;
   endfunction

   function logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function void mix_quarter(int a, int b, int c, int d);
      wk[a] = wk[a] + wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 16);
      wk[c] = wk[c] + wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 12);
      wk[a] = wk[a] + wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 8);
      wk[c] = wk[c] + wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 7);
   endfunction

   // One keystream block keyed by the first 32 pool bytes, zero nonce and counter.
   function void keystream(output logic [7:0] ks[64]);
      logic [31:0] seed[16];
      seed[0] = 32'h61707865; seed[1] = 32'h3320646e;
      seed[2] = 32'h79622d32; seed[3] = 32'h6b206574;
      for (int i = 0; i < 8; i++)
         seed[4 + i] = {pool[4*i+3], pool[4*i+2], pool[4*i+1], pool[4*i]};
      for (int i = 12; i < 16; i++) seed[i] = 32'd0;
      wk = seed;
      for (int r = 0; r < 10; r++) begin
         mix_quarter(0, 4, 8, 12);  mix_quarter(1, 5, 9, 13);
         mix_quarter(2, 6, 10, 14); mix_quarter(3, 7, 11, 15);
         mix_quarter(0, 5, 10, 15); mix_quarter(1, 6, 11, 12);
         mix_quarter(2, 7, 8, 13);  mix_quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
         logic [31:0] w;
         w = wk[i] + seed[i];
         for (int b = 0; b < 4; b++) ks[4*i + b] = w[8*b +: 8];
      end
   endfunction

   function void push(logic [7:0] ob, logic ok, logic eor);
      result_type r;
      r.out_byte = ob;
      r.granted = ok;
      r.end_of_run = eor;
      r.entropy_count = 13'(credit);
      pending.push_back(r);
   endfunction

   // Note one accepted input item and queue its expected results.
   function void note_item(logic [1:0] op, logic [7:0] data, logic present,
                           logic lst, logic [12:0] amount, logic [6:0] len);
      logic [7:0] ks[64];
      case (op)
         epce_pkg::OP_MIX: begin
            if (present) begin
               pool[wr_pos] = pool[wr_pos] ^ data;
               wr_pos = (wr_pos + 1) % 512;
            end
            if (lst) credit = (credit + amount > 4096) ? 4096 : credit + amount;
            push(8'd0, 1'b1, 1'b1);
         end
         epce_pkg::OP_DEBIT: begin
            credit = (credit > amount) ? credit - amount : 0;
            push(8'd0, 1'b1, 1'b1);
         end
         epce_pkg::OP_EXTRACT: begin
            if (len == 0) begin
               push(8'd0, 1'b1, 1'b1);
            end else if (len > 64 || credit < 8 * len) begin
               n_refusals++;
               push(8'd0, 1'b0, 1'b1);
            end else begin
               n_grants++;
               credit = credit - 8 * len;
               keystream(ks);
               for (int k = 0; k < len; k++) push(ks[k], 1'b1, k == len - 1);
            end
         end
         default: push(8'd0, 1'b0, 1'b1);
      endcase
   endfunction

   // Compare one emitted result with the oldest expectation.
   function void check_result(logic [7:0] ob, logic ok, logic eor, logic [12:0] cnt);
      result_type e;
      n_results++;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result byte=%h granted=%b end=%b count=%0d",
                  $time, ob, ok, eor, cnt);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (ob !== e.out_byte) begin
         $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, ob);
         errors++;
      end
      if (ok !== e.granted) begin
         $display("%0t: granted expected %b actual %b", $time, e.granted, ok);
         errors++;
      end
      if (eor !== e.end_of_run) begin
         $display("%0t: end_of_run expected %b actual %b", $time, e.end_of_run, eor);
         errors++;
      end
      if (cnt !== e.entropy_count) begin
         $display("%0t: entropy_count expected %0d actual %0d",
                  $time, e.entropy_count, cnt);
         errors++;
      end
   endfunction
endclass

module tb_entropy_pool_chacha_extractor_top;
   import epce_pkg::*;

   localparam int STALL_LIMIT = 3000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_last;
   logic [12:0] req_amount_bits;
   logic [6:0]  req_out_len;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_granted;
   logic        rsp_end_of_run;
   logic [12:0] rsp_entropy_count;

   pool_scoreboard sb;
   int idle_pct;
   int quiet_cycles;
   int n_items;

   entropy_pool_chacha_extractor_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_data_byte(req_data_byte),
      .req_byte_present(req_byte_present), .req_last(req_last),
      .req_amount_bits(req_amount_bits), .req_out_len(req_out_len),
      .rsp_valid(rsp_valid), .rsp_out_byte(rsp_out_byte),
      .rsp_granted(rsp_granted), .rsp_end_of_run(rsp_end_of_run),
      .rsp_entropy_count(rsp_entropy_count)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results are checked as they appear; they can never be held off.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_out_byte, rsp_granted, rsp_end_of_run, rsp_entropy_count);
   end

   // Watchdog: ends the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired at %0t", $time);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one item, idling first at random, and return once it is accepted.
   task automatic send_item(logic [1:0] op, logic [7:0] data, logic present,
                            logic lst, logic [12:0] amount, logic [6:0] len);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      req_byte_present <= present;
      req_last <= lst;
      req_amount_bits <= amount;
      req_out_len <= len;
      do @(posedge clock); while (busy);
      sb.note_item(op, data, present, lst, amount, len);
      n_items++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // One random item; mostly mixes with credit so that extractions get granted.
   task automatic random_item();
      int pick;
      logic [12:0] amt;
      logic [6:0]  len;
      pick = $urandom_range(99);
      amt = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 700));
      if ($urandom_range(7) == 0) len = 7'($urandom);
      else if ($urandom_range(3) == 0) len = 7'($urandom_range(1, 64));
      else len = 7'($urandom_range(1, 12));
      if (pick < 58)
         send_item(OP_MIX, 8'($urandom), $urandom_range(9) != 0,
                   $urandom_range(2) == 0, amt, 7'($urandom));
      else if (pick < 80)
         send_item(OP_EXTRACT, 8'($urandom), 1'($urandom), 1'($urandom), 13'($urandom), len);
      else if (pick < 95)
         send_item(OP_DEBIT, 8'($urandom), 1'($urandom), 1'($urandom),
                   13'($urandom_range(0, 300)), 7'($urandom));
      else
         send_item(2'd3, 8'($urandom), 1'($urandom), 1'($urandom), amt, len);
   endtask

   initial begin
      sb = new();
      idle_pct = 0;
      n_items = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_MIX;
      req_data_byte = 8'd0;
      req_byte_present = 1'b0;
      req_last = 1'b0;
      req_amount_bits = 13'd0;
      req_out_len = 7'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: refusal on an empty pool, field extremes, saturation, odd lengths.
      send_item(OP_EXTRACT, 8'd0, 1'b0, 1'b0, 13'd0, 7'd1);
      send_item(OP_MIX, 8'hFF, 1'b1, 1'b0, 13'd0, 7'd0);
      send_item(OP_MIX, 8'h00, 1'b1, 1'b0, 13'd0, 7'd0);
      send_item(OP_MIX, 8'hA5, 1'b1, 1'b1, 13'h1FFF, 7'h7F);
      send_item(OP_EXTRACT, 8'd0, 1'b0, 1'b0, 13'd0, 7'd64);
      send_item(OP_EXTRACT, 8'd0, 1'b0, 1'b0, 13'd0, 7'd0);
      send_item(OP_MIX, 8'h3C, 1'b0, 1'b1, 13'd4096, 7'd0);
      send_item(OP_EXTRACT, 8'd0, 1'b0, 1'b0, 13'd0, 7'd65);
      send_item(OP_EXTRACT, 8'd0, 1'b0, 1'b0, 13'd0, 7'd127);
      send_item(2'd3, 8'hFF, 1'b1, 1'b1, 13'h1FFF, 7'd5);
      send_item(OP_DEBIT, 8'd0, 1'b0, 1'b0, 13'd100, 7'd0);
      send_item(OP_EXTRACT, 8'd0, 1'b0, 1'b0, 13'd0, 7'd1);
      send_item(OP_DEBIT, 8'hFF, 1'b1, 1'b1, 13'h1FFF, 7'h7F);
      send_item(OP_EXTRACT, 8'd0, 1'b0, 1'b0, 13'd0, 7'd1);
      drain();

      // Walk the write position well past the key bytes of the pool.
      for (int i = 0; i < 200; i++)
         send_item(OP_MIX, 8'($urandom), 1'b1, i % 64 == 63, 13'd200, 7'd0);
      send_item(OP_EXTRACT, 8'd0, 1'b0, 1'b0, 13'd0, 7'd32);

      // Random phases with different sender idle rates.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: idle_pct = 0;
            1: idle_pct = 74;
            2: idle_pct = 0;
            default: idle_pct = 34;
         endcase
         for (int i = 0; i < 42; i++) random_item();
         if (ph == 1) drain();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d items, checked %0d results: %0d extractions granted, %0d refused.",
               n_items, sb.n_results, sb.n_grants, sb.n_refusals);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results still expected", sb.errors,
                  sb.pending.size());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
